[design/bfa_pkg.sv]
package bfa_pkg;

   localparam int FRAME_W = 13;
   localparam int INDEX_W = 12;
   localparam int KIND_W  = 3;

   localparam int BFA_MAX_FRAMES = 4096;
   localparam int BFA_WORD_BITS  = 64;

   localparam logic [FRAME_W-1:0] TOTAL_RESET = 13'd4096;

   localparam logic [KIND_W-1:0] KIND_ALLOC_ONE   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FREE_ONE    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ALLOC_RANGE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FREE_RANGE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR_ALL   = 3'd4;

endpackage

[design/bfa_if.sv]
interface bfa_req_if import bfa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  req_type;
   logic [INDEX_W-1:0] frame_index;
   logic [FRAME_W-1:0] frame_count;

   modport source (output valid, req_type, frame_index, frame_count, input ready);
   modport sink   (input valid, req_type, frame_index, frame_count, output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] first_frame;
   logic               success;
   logic [FRAME_W-1:0] used_count;

   modport source (output valid, first_frame, success, used_count, input ready);
   modport sink   (input valid, first_frame, success, used_count, output ready);
endinterface

interface bfa_csr_if import bfa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FRAME_W-1:0] total_frames;

   modport source (output valid, total_frames, input ready);
   modport sink   (input valid, total_frames, output ready);
endinterface

[design/bitmap_frame_allocator.sv]
// channel   dir  handshake      word
// req_bus   in   valid/ready    req_type, frame_index, frame_count
// rsp_bus   out  valid/ready    first_frame, success, used_count
// csr_bus   in   valid/ready    total_frames (always ready)
//
// One request at a time; every word goes through the single-port bitmap RAM
// (registered read), so the work grows with the bitmap words touched:
// alloc scans words upward, then marks the run downward; free skips words
// below the run, then reads and clears each word in the run; clear all
// writes every word. Reset is synchronous; afterwards a clearing pass zeroes
// the bitmap, req_bus.ready stays low meanwhile.
// Results sit in an output register; a stalled rsp_bus holds only the final step.
module bitmap_frame_allocator import bfa_pkg::*; #(
   parameter int MAX_FRAMES = BFA_MAX_FRAMES,
   parameter int WORD_BITS  = BFA_WORD_BITS
) (
   input  logic         clock,
   input  logic         reset,
   bfa_req_if.sink      req_bus,
   bfa_rsp_if.source    rsp_bus,
   bfa_csr_if.sink      csr_bus
);

   localparam int WORD_COUNT = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int BASE_W     = FRAME_W + 1;
   localparam int CNT_W      = $clog2(WORD_BITS + 1);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SCAN_RD, ST_SCAN_EV, ST_MARK_RD, ST_MARK_EV,
      ST_FREE_SEEK, ST_FREE_RD, ST_FREE_EV, ST_DONE
   } state_type;

   function automatic logic [WORD_BITS-1:0] span_mask(input logic [BASE_W-1:0] base,
                                                      input logic [BASE_W-1:0] lo,
                                                      input logic [BASE_W-1:0] hi);
      logic [WORD_BITS-1:0] m;
      logic [BASE_W-1:0]    f;
      m = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         f = base + BASE_W'(j);
         m[j] = (f >= lo) && (f < hi);
      end
      return m;
   endfunction

   function automatic logic [CNT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
      logic [CNT_W-1:0] r;
      r = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (v[j]) r = CNT_W'(j);
      end
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] highest_set(input logic [WORD_BITS-1:0] v);
      logic [CNT_W-1:0] r;
      r = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         if (v[j]) r = CNT_W'(j);
      end
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] popcount(input logic [WORD_BITS-1:0] v);
      logic [CNT_W-1:0] r;
      r = '0;
      for (int j = 0; j < WORD_BITS; j++) r = r + CNT_W'(v[j]);
      return r;
   endfunction

   logic [WORD_BITS-1:0] mem [WORD_COUNT];

   state_type            state_ff;
   logic [ADDR_W-1:0]    w_ff;
   logic [BASE_W-1:0]    base_ff;
   logic [BASE_W-1:0]    lo_ff;
   logic [BASE_W-1:0]    hi_ff;
   logic [FRAME_W-1:0]   run_ff;
   logic [FRAME_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]     pop_ff;
   logic [FRAME_W-1:0]   used_ff;
   logic [FRAME_W-1:0]   total_ff;
   logic [INDEX_W-1:0]   res_start_ff;
   logic                 res_ok_ff;
   logic                 clear_resp_ff;
   logic [WORD_BITS-1:0] rd_ff;
   logic                 rsp_valid_ff;
   logic [INDEX_W-1:0]   rsp_start_ff;
   logic                 rsp_ok_ff;
   logic [FRAME_W-1:0]   rsp_used_ff;

   logic [FRAME_W-1:0]     lim;
   logic [FRAME_W-1:0]     req_cnt;
   logic [BASE_W-1:0]      req_end;
   logic [WORD_BITS-1:0]   span;
   logic [WORD_BITS-1:0]   free_vec;
   logic                   all_free;
   logic [CNT_W-1:0]       head_free;
   logic [CNT_W-1:0]       tail_free;
   logic [2*WORD_BITS-1:0] pw;
   logic [2*WORD_BITS-1:0] acc;
   logic [WORD_BITS-1:0]   fit;
   logic                   hit_a;
   logic                   hit_b;
   logic [BASE_W-1:0]      hit_start;
   logic [FRAME_W-1:0]     run_in;
   logic [BASE_W-1:0]      base_up;
   logic [BASE_W-1:0]      base_dn;
   logic [CNT_W-1:0]       pop_in;
   logic [FRAME_W-1:0]     used_in;
   logic                   mem_we;
   logic [WORD_BITS-1:0]   mem_wdata;
   logic                   accept;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.first_frame = rsp_start_ff;
   assign rsp_bus.success     = rsp_ok_ff;
   assign rsp_bus.used_count  = rsp_used_ff;

   always_comb begin
      lim = (32'(total_ff) > 32'(MAX_FRAMES)) ? FRAME_W'(MAX_FRAMES) : total_ff;
      req_cnt = (req_bus.req_type == KIND_ALLOC_ONE || req_bus.req_type == KIND_FREE_ONE)
                ? FRAME_W'(1) : req_bus.frame_count;
      req_end = BASE_W'(req_bus.frame_index) + BASE_W'(req_cnt);
      if (req_end > BASE_W'(lim)) req_end = BASE_W'(lim);

      span     = span_mask(base_ff, lo_ff, hi_ff);
      free_vec = ~rd_ff & span;
      all_free = &free_vec;
      tail_free = all_free ? CNT_W'(WORD_BITS) : lowest_set(~free_vec);
      head_free = CNT_W'(WORD_BITS - 1) - highest_set(~free_vec);

      // window AND by doubling: fit[s] set when cnt free bits start at s
      pw  = {{WORD_BITS{1'b0}}, free_vec};
      acc = '1;
      for (int i = 0; i < CNT_W; i++) begin
         if (cnt_ff[i]) acc = pw & (acc >> (1 << i));
         pw = pw & (pw >> (1 << i));
      end
      fit = acc[WORD_BITS-1:0];

      hit_a = ({1'b0, run_ff} + BASE_W'(tail_free)) >= {1'b0, cnt_ff};
      hit_b = (|fit) && (cnt_ff <= FRAME_W'(WORD_BITS));
      hit_start = hit_a ? (base_ff - {1'b0, run_ff})
                        : (base_ff + BASE_W'(lowest_set(fit)));
      run_in = all_free ? FRAME_W'(run_ff + FRAME_W'(WORD_BITS)) : FRAME_W'(head_free);

      base_up = base_ff + BASE_W'(WORD_BITS);
      base_dn = base_ff - BASE_W'(WORD_BITS);
      pop_in  = popcount(rd_ff & span);
      used_in = used_ff - FRAME_W'(pop_ff);

      mem_we    = 1'b0;
      mem_wdata = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
         end
         ST_MARK_EV: begin
            mem_we    = 1'b1;
            mem_wdata = rd_ff | span;
         end
         ST_FREE_EV: begin
            mem_we    = 1'b1;
            mem_wdata = rd_ff & ~span;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[w_ff] <= mem_wdata;
      rd_ff <= mem[w_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         w_ff          <= '0;
         clear_resp_ff <= 1'b0;
         total_ff      <= TOTAL_RESET;
         used_ff       <= '0;
         pop_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_bus.valid) total_ff <= csr_bus.total_frames;
         if (rsp_bus.ready && state_ff != ST_DONE) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_CLEAR: begin
               if (w_ff == ADDR_W'(WORD_COUNT - 1)) begin
                  state_ff      <= clear_resp_ff ? ST_DONE : ST_IDLE;
                  clear_resp_ff <= 1'b0;
               end else begin
                  w_ff <= w_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  w_ff         <= '0;
                  base_ff      <= '0;
                  run_ff       <= '0;
                  pop_ff       <= '0;
                  cnt_ff       <= req_cnt;
                  res_start_ff <= '0;
                  res_ok_ff    <= 1'b1;
                  unique case (req_bus.req_type)
                     KIND_ALLOC_ONE, KIND_ALLOC_RANGE: begin
                        lo_ff <= '0;
                        hi_ff <= BASE_W'(lim);
                        if (req_cnt == '0 || req_cnt > lim) begin
                           res_ok_ff <= 1'b0;
                           state_ff  <= ST_DONE;
                        end else begin
                           state_ff <= ST_SCAN_RD;
                        end
                     end
                     KIND_FREE_ONE, KIND_FREE_RANGE: begin
                        lo_ff    <= BASE_W'(req_bus.frame_index);
                        hi_ff    <= req_end;
                        state_ff <= ST_FREE_SEEK;
                     end
                     KIND_CLEAR_ALL: begin
                        used_ff       <= '0;
                        clear_resp_ff <= 1'b1;
                        state_ff      <= ST_CLEAR;
                     end
                     default: begin
                        res_ok_ff <= 1'b0;
                        state_ff  <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_SCAN_RD: begin
               state_ff <= ST_SCAN_EV;
            end
            ST_SCAN_EV: begin
               if (hit_a || hit_b) begin
                  lo_ff    <= hit_start;
                  hi_ff    <= hit_start + BASE_W'(cnt_ff);
                  state_ff <= ST_MARK_RD;
               end else if (base_up >= hi_ff) begin
                  res_ok_ff <= 1'b0;
                  state_ff  <= ST_DONE;
               end else begin
                  run_ff   <= run_in;
                  base_ff  <= base_up;
                  w_ff     <= w_ff + 1'b1;
                  state_ff <= ST_SCAN_RD;
               end
            end
            ST_MARK_RD: begin
               state_ff <= ST_MARK_EV;
            end
            ST_MARK_EV: begin
               if (base_ff <= lo_ff) begin
                  used_ff      <= used_ff + cnt_ff;
                  res_start_ff <= lo_ff[INDEX_W-1:0];
                  state_ff     <= ST_DONE;
               end else begin
                  base_ff  <= base_dn;
                  w_ff     <= w_ff - 1'b1;
                  state_ff <= ST_MARK_RD;
               end
            end
            ST_FREE_SEEK: begin
               used_ff <= used_in;
               pop_ff  <= '0;
               if (base_ff >= hi_ff) begin
                  state_ff <= ST_DONE;
               end else if (base_up <= lo_ff) begin
                  base_ff <= base_up;
                  w_ff    <= w_ff + 1'b1;
               end else begin
                  state_ff <= ST_FREE_RD;
               end
            end
            ST_FREE_RD: begin
               state_ff <= ST_FREE_EV;
            end
            ST_FREE_EV: begin
               pop_ff   <= pop_in;
               base_ff  <= base_up;
               if (base_up < hi_ff) w_ff <= w_ff + 1'b1;
               state_ff <= ST_FREE_SEEK;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_start_ff <= res_start_ff;
                  rsp_ok_ff    <= res_ok_ff;
                  rsp_used_ff  <= used_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTH
   // bitmap is being cleared right after reset
   assert property (@(posedge clock) $past(reset) |-> !req_bus.ready)
      else $error("request taken during clearing pass");

   assert property (@(posedge clock) disable iff (reset) accept |=> !req_bus.ready)
      else $error("ready stayed high after accepting a word");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MARK_EV |-> (mem_wdata & rd_ff) == rd_ff)
      else $error("allocation cleared an in-use frame");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FREE_EV |-> (mem_wdata & ~rd_ff) == '0)
      else $error("free set a frame");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside completion");
`endif

endmodule
